@@ hdl/aipc_pkg.sv @@
// Package for the aligned interval pulse counter.
// Holds field widths, interval constants and command codes.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package aipc_pkg;

  // Widths of the transaction fields and of the register
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned IntervalW = 17;

  typedef logic [TimeW-1:0]     time_t;
  typedef logic [CountW-1:0]    count_t;
  typedef logic [IntervalW-1:0] ival_t;

  // Interval limits and alignment constants, in seconds
  localparam ival_t MIN_INTERVAL    = 17'd10;
  localparam ival_t MINUTE_SECS     = 17'd60;
  localparam ival_t ALIGN_LONG_SECS = 17'd600;
  localparam ival_t MAX_INTERVAL    = 17'd86400;
  localparam ival_t REQUEST_RESET   = 17'd60;

  // Input command codes
  localparam logic CMD_ARM   = 1'b0;
  localparam logic CMD_PULSE = 1'b1;

endpackage : aipc_pkg

`default_nettype wire

@@ hdl/aligned_interval_pulse_counter.sv @@
// Top level of the aligned interval pulse counter: sequencer plus one
// shared bit-serial remainder unit. Depends on aipc_pkg.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+-------------------------------------
//   in       | input     | in_valid_i/in_ready_o  | command_i, now_seconds_i
//   out      | output    | out_valid_o/out_ready_i| pulse_count_o, interval_end_time_o,
//            |           |                        | interval_seconds_o
//   cfg      | input     | cfg_we_i (no wait)     | cfg_wdata_i (interval request)
//
// A pulse that closes no interval, or arrives before arming, is taken without leaving idle.
// A pulse that closes an interval first waits for the output register, then runs the
// 32-step remainder for the deadline catch-up.
// An arm transaction runs a 17-step (skipped for requests below 10), a 32-step and,
// for intervals below a minute, a 6-step remainder one after the other on the same unit.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output register holds its transaction and blocks the next report;
// while that report waits, no input is taken.
`default_nettype none

module aligned_interval_pulse_counter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [aipc_pkg::IntervalW-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             command_i,
  input  wire logic [aipc_pkg::TimeW-1:0]       now_seconds_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [aipc_pkg::CountW-1:0]           pulse_count_o,
  output logic [aipc_pkg::TimeW-1:0]            interval_end_time_o,
  output logic [aipc_pkg::IntervalW-1:0]        interval_seconds_o
);

  // Sequencer state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_N_DIV  = 4'd1;
  localparam logic [3:0] S_N_FIN  = 4'd2;
  localparam logic [3:0] S_A_DIVN = 4'd3;
  localparam logic [3:0] S_A_S    = 4'd4;
  localparam logic [3:0] S_A_DIVS = 4'd5;
  localparam logic [3:0] S_A_FIN  = 4'd6;
  localparam logic [3:0] S_A_SET  = 4'd7;
  localparam logic [3:0] S_P_EMIT = 4'd8;
  localparam logic [3:0] S_P_DIV  = 4'd9;
  localparam logic [3:0] S_P_FIN  = 4'd10;
  localparam logic [3:0] S_P_SET  = 4'd11;

  localparam int unsigned ShortPad = aipc_pkg::TimeW - aipc_pkg::IntervalW;

  logic [3:0]             state_q, state_d;
  aipc_pkg::ival_t        req_q, req_d;
  aipc_pkg::count_t       tally_q, tally_d;
  aipc_pkg::time_t        deadline_q, deadline_d;
  aipc_pkg::ival_t        iv_q, iv_d;
  logic                   armed_q, armed_d;
  aipc_pkg::time_t        now_q, now_d;
  aipc_pkg::time_t        wrk_q, wrk_d;

  // Remainder unit registers
  aipc_pkg::ival_t        rem_q, rem_d;
  aipc_pkg::time_t        dvd_q, dvd_d;
  aipc_pkg::ival_t        div_q, div_d;
  logic [5:0]             cnt_q, cnt_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  aipc_pkg::count_t       oc_q, oc_d;
  aipc_pkg::time_t        oe_q, oe_d;
  aipc_pkg::ival_t        os_q, os_d;

  // Combinational helpers
  logic [aipc_pkg::IntervalW:0]   shifted;
  logic [aipc_pkg::IntervalW+1:0] trial;
  aipc_pkg::ival_t                rem_step;
  aipc_pkg::ival_t                clamp;
  aipc_pkg::ival_t                iv_norm;
  aipc_pkg::time_t                overdue;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign shifted  = {rem_q, dvd_q[aipc_pkg::TimeW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, div_q};
  assign rem_step = trial[aipc_pkg::IntervalW+1] ? shifted[aipc_pkg::IntervalW-1:0]
                                                 : trial[aipc_pkg::IntervalW-1:0];

  // Request clamped to one day, normalised interval and time past the deadline.
  assign clamp   = (req_q > aipc_pkg::MAX_INTERVAL) ? aipc_pkg::MAX_INTERVAL : req_q;
  assign iv_norm = wrk_q[aipc_pkg::IntervalW-1:0] - rem_q;
  assign overdue = now_q - deadline_q;

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign pulse_count_o       = oc_q;
  assign interval_end_time_o = oe_q;
  assign interval_seconds_o  = os_q;

  // Sequencer and datapath next-state logic
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    tally_d     = tally_q;
    deadline_d  = deadline_q;
    iv_d        = iv_q;
    armed_d     = armed_q;
    now_d       = now_q;
    wrk_d       = wrk_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    oc_d        = oc_q;
    oe_d        = oe_q;
    os_d        = os_q;

    if (cfg_we_i) begin
      req_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == aipc_pkg::CMD_ARM) begin
            now_d = now_seconds_i;
            if (clamp < aipc_pkg::MIN_INTERVAL) begin
              // Short request: interval is fixed, go straight to alignment.
              iv_d    = aipc_pkg::MIN_INTERVAL;
              rem_d   = '0;
              dvd_d   = now_seconds_i;
              div_d   = aipc_pkg::MINUTE_SECS;
              cnt_d   = 6'd32;
              state_d = S_A_DIVN;
            end else begin
              wrk_d   = {{ShortPad{1'b0}}, clamp};
              rem_d   = '0;
              dvd_d   = {clamp, {ShortPad{1'b0}}};
              div_d   = (clamp < aipc_pkg::MINUTE_SECS) ? aipc_pkg::MIN_INTERVAL
                                                        : aipc_pkg::MINUTE_SECS;
              cnt_d   = 6'(aipc_pkg::IntervalW);
              state_d = S_N_DIV;
            end
          end else if (armed_q) begin
            if (now_seconds_i > deadline_q) begin
              now_d   = now_seconds_i;
              state_d = S_P_EMIT;
            end else if (tally_q != '1) begin
              tally_d = tally_q + aipc_pkg::count_t'(1);
            end
          end
        end
      end

      S_N_DIV, S_A_DIVN, S_A_DIVS, S_P_DIV: begin
        rem_d = rem_step;
        dvd_d = {dvd_q[aipc_pkg::TimeW-2:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          case (state_q)
            S_N_DIV:  state_d = S_N_FIN;
            S_A_DIVN: state_d = (iv_q < aipc_pkg::MINUTE_SECS) ? S_A_S : S_A_FIN;
            S_A_DIVS: state_d = S_A_FIN;
            default:  state_d = S_P_FIN;
          endcase
        end
      end

      // Interval rounded down; now find the start within the minute or ten minutes.
      S_N_FIN: begin
        iv_d    = iv_norm;
        rem_d   = '0;
        dvd_d   = now_q;
        div_d   = (iv_norm < aipc_pkg::MINUTE_SECS) ? aipc_pkg::MINUTE_SECS
                                                    : aipc_pkg::ALIGN_LONG_SECS;
        cnt_d   = 6'd32;
        state_d = S_A_DIVN;
      end

      // Seconds within the minute, reduced modulo the short interval.
      S_A_S: begin
        dvd_d   = {rem_q[5:0], {(aipc_pkg::TimeW-6){1'b0}}};
        rem_d   = '0;
        div_d   = iv_q;
        cnt_d   = 6'd6;
        state_d = S_A_DIVS;
      end

      S_A_FIN: begin
        wrk_d   = now_q - {{ShortPad{1'b0}}, rem_q};
        state_d = S_A_SET;
      end

      S_A_SET: begin
        deadline_d = wrk_q + {{ShortPad{1'b0}}, iv_q};
        armed_d    = 1'b1;
        state_d    = S_IDLE;
      end

      // Report the closed interval once the output register is free.
      S_P_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          oc_d        = tally_q;
          oe_d        = deadline_q;
          os_d        = iv_q;
          tally_d     = aipc_pkg::count_t'(1);
          wrk_d       = overdue;
          deadline_d  = deadline_q + {{ShortPad{1'b0}}, iv_q};
          rem_d       = '0;
          dvd_d       = overdue;
          div_d       = iv_q;
          cnt_d       = 6'd32;
          state_d     = S_P_DIV;
        end
      end

      // Catch-up: whole intervals elapsed beyond the first.
      S_P_FIN: begin
        if (wrk_q > {{ShortPad{1'b0}}, iv_q}) begin
          wrk_d = wrk_q - {{ShortPad{1'b0}}, rem_q};
        end else begin
          wrk_d = '0;
        end
        state_d = S_P_SET;
      end

      S_P_SET: begin
        deadline_d = deadline_q + wrk_q;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= aipc_pkg::REQUEST_RESET;
      tally_q     <= '0;
      deadline_q  <= '0;
      iv_q        <= '0;
      armed_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      tally_q     <= tally_d;
      deadline_q  <= deadline_d;
      iv_q        <= iv_d;
      armed_q     <= armed_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    wrk_q <= wrk_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    oc_q  <= oc_d;
    oe_q  <= oe_d;
    os_q  <= os_d;
  end

endmodule : aligned_interval_pulse_counter

`default_nettype wire

@@ hdl/aipc_checker.sv @@
// Port-level checker for the aligned interval pulse counter, with its bind.
// Depends on aipc_pkg and on the top level's port list.
`default_nettype none

module aipc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           command_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [aipc_pkg::CountW-1:0]    pulse_count_o,
  input wire logic [aipc_pkg::TimeW-1:0]     interval_end_time_o,
  input wire logic [aipc_pkg::IntervalW-1:0] interval_seconds_o
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_count_o)
      && $stable(interval_end_time_o) && $stable(interval_seconds_o))
    else $error("stalled result transaction changed");

  // A reported interval is always a normalised length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> interval_seconds_o >= aipc_pkg::MIN_INTERVAL
      && interval_seconds_o <= aipc_pkg::MAX_INTERVAL)
    else $error("reported interval out of range");

  // Arming runs the remainder unit, so the input side closes for a while.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == aipc_pkg::CMD_ARM |=> !in_ready_o)
    else $error("arm transaction finished in one cycle");

  // A new report starts the deadline catch-up, during which no input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("input ready while catch-up runs");

endmodule : aipc_checker

bind aligned_interval_pulse_counter aipc_checker u_aipc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .command_i           (command_i),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .pulse_count_o       (pulse_count_o),
  .interval_end_time_o (interval_end_time_o),
  .interval_seconds_o  (interval_seconds_o)
);

`default_nettype wire

@@ tb/sv/tb_aligned_interval_pulse_counter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the aligned interval pulse counter: drives arm and
// pulse transactions, predicts every interval report and checks each one on arrival.
// Depends on aipc_pkg and the aligned_interval_pulse_counter RTL.

module tb_aligned_interval_pulse_counter;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 3;
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned TimeoutCycles = 500000;
  localparam int unsigned RandomPhases  = 13;
  localparam int unsigned PhaseItems    = 46;

  typedef struct {
    logic            command;
    aipc_pkg::time_t now;
  } meter_item_t;

  typedef struct {
    aipc_pkg::count_t count;
    aipc_pkg::time_t  end_time;
    aipc_pkg::ival_t  secs;
  } report_t;

  // Clock, reset and the signals around the block
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  aipc_pkg::ival_t  cfg_wdata  = '0;
  logic             in_valid   = 1'b0;
  logic             in_command = aipc_pkg::CMD_ARM;
  aipc_pkg::time_t  in_now     = '0;
  logic             out_ready  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  aipc_pkg::count_t out_count;
  aipc_pkg::time_t  out_end_time;
  aipc_pkg::ival_t  out_secs;

  // Transaction feed for the driver and the reports still awaited
  meter_item_t pending_items [$];
  report_t     expected_reports [$];
  meter_item_t next_item;
  logic        in_taken = 1'b0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  // Shadow of the block's register and state
  aipc_pkg::ival_t  request_shadow  = aipc_pkg::REQUEST_RESET;
  aipc_pkg::count_t tally           = '0;
  aipc_pkg::time_t  deadline        = '0;
  aipc_pkg::ival_t  active_interval = '0;
  logic             armed           = 1'b0;

  // Stimulus generator state: last time queued and the interval it runs on
  aipc_pkg::time_t gen_time = '0;
  int unsigned     gen_iv   = 60;

  // Run statistics
  int unsigned errors        = 0;
  int unsigned arms_seen     = 0;
  int unsigned pulses_seen   = 0;
  int unsigned reports_seen  = 0;
  int unsigned catchups      = 0;
  int unsigned settings_used = 0;
  int unsigned items_queued  = 0;

  aipc_pkg::ival_t corner_requests [0:8] = '{17'd0, 17'd9, 17'd10, 17'd59, 17'd60,
                                             17'd86400, 17'h1FFFF, 17'd61, 17'd599};

  aligned_interval_pulse_counter dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .command_i           (in_command),
    .now_seconds_i       (in_now),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .pulse_count_o       (out_count),
    .interval_end_time_o (out_end_time),
    .interval_seconds_o  (out_secs)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Clamp to a day, then round down to a multiple of 10 or of 60.
  function automatic aipc_pkg::ival_t normalise_interval(aipc_pkg::ival_t request);
    int unsigned req;
    req = 32'(request);
    if (req > aipc_pkg::MAX_INTERVAL) req = 32'(aipc_pkg::MAX_INTERVAL);
    if (req < aipc_pkg::MIN_INTERVAL) return aipc_pkg::MIN_INTERVAL;
    if (req < aipc_pkg::MINUTE_SECS)
      return aipc_pkg::ival_t'((req / aipc_pkg::MIN_INTERVAL) * aipc_pkg::MIN_INTERVAL);
    return aipc_pkg::ival_t'((req / aipc_pkg::MINUTE_SECS) * aipc_pkg::MINUTE_SECS);
  endfunction

  // Apply one accepted transaction to the shadow state and queue any report it closes.
  task automatic forecast_report(logic command, aipc_pkg::time_t now);
    aipc_pkg::ival_t iv;
    aipc_pkg::time_t start;
    aipc_pkg::time_t secs_in_min;
    aipc_pkg::time_t gap;
    longint unsigned step;
    longint unsigned span;
    longint unsigned moved;
    report_t         rep;
    if (command == aipc_pkg::CMD_ARM) begin
      arms_seen++;
      iv = normalise_interval(request_shadow);
      if (iv < aipc_pkg::MINUTE_SECS) begin
        // Short intervals align within the current minute.
        secs_in_min = now % aipc_pkg::MINUTE_SECS;
        start = now - secs_in_min + (secs_in_min / iv) * iv;
      end else begin
        // Longer ones align to the ten-minute boundary.
        start = now - now % aipc_pkg::ALIGN_LONG_SECS;
      end
      active_interval = iv;
      deadline = start + iv;
      armed = 1'b1;
    end else begin
      pulses_seen++;
      if (armed) begin
        if (now > deadline) begin
          rep.count    = tally;
          rep.end_time = deadline;
          rep.secs     = active_interval;
          expected_reports.push_back(rep);
          // Move the deadline to or past the current time by whole intervals.
          step = 64'(active_interval);
          gap  = now - deadline;
          span = 64'(gap);
          if (span > step) begin
            moved = deadline + (span / step) * step + step;
            catchups++;
          end else begin
            moved = deadline + step;
          end
          deadline = moved[aipc_pkg::TimeW-1:0];
          tally = '0;
        end
        // The tally saturates; reaching it would take far more pulses than any run.
        if (tally != '1) tally++;
      end
    end
  endtask

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      errors++;
    end
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report, expected none, actual count %0d end %0d secs %0d",
               $time, out_count, out_end_time, out_secs);
      errors++;
    end else begin
      want = expected_reports.pop_front();
      reports_seen++;
      check_field("pulse_count", want.count, out_count);
      check_field("interval_end_time", want.end_time, out_end_time);
      check_field("interval_seconds", 32'(want.secs), 32'(out_secs));
    end
  endtask

  // Driver: presents the next transaction at the falling edge and randomises the stall.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid   <= 1'b1;
          in_command <= next_item.command;
          in_now     <= next_item.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: checks reports first, then predicts from the transaction taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) check_report();
      if (in_valid && in_ready) forecast_report(in_command, in_now);
    end
  end

  task automatic push_item(logic command, aipc_pkg::time_t now);
    meter_item_t item;
    item.command = command;
    item.now     = now;
    pending_items.push_back(item);
    items_queued++;
    gen_time = now;
    if (command == aipc_pkg::CMD_ARM) gen_iv = 32'(normalise_interval(request_shadow));
  endtask

  // One pulse a little after the last, across a deadline, far ahead, back in time, or anywhere.
  task automatic queue_pulse();
    int unsigned     roll;
    aipc_pkg::time_t t;
    roll = $urandom_range(99);
    if (roll < 60) t = gen_time + $urandom_range(gen_iv / 3);
    else if (roll < 85) t = gen_time + $urandom_range(2 * gen_iv, gen_iv / 3);
    else if (roll < 93) t = gen_time + gen_iv * $urandom_range(50, 2) + $urandom_range(gen_iv);
    else if (roll < 98) t = gen_time - $urandom_range(gen_iv);
    else t = $urandom;
    push_item(aipc_pkg::CMD_PULSE, t);
  endtask

  // An arm at a random base time followed by a run of pulses, now and then re-armed.
  task automatic queue_sequence(int unsigned pulses);
    int unsigned     pick;
    int unsigned     iv;
    aipc_pkg::time_t base;
    iv   = 32'(normalise_interval(request_shadow));
    pick = $urandom_range(9);
    if (pick == 0) base = $urandom_range(1000);
    else if (pick == 1) base = 32'hFFFF_FFFF - $urandom_range(4 * iv);
    else base = $urandom;
    push_item(aipc_pkg::CMD_ARM, base);
    repeat (pulses) begin
      if ($urandom_range(99) < 3) push_item(aipc_pkg::CMD_ARM, gen_time);
      queue_pulse();
    end
  endtask

  // Wait for every transaction and report to pass, then let an arm still in work finish.
  task automatic wait_until_idle();
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_request(aipc_pkg::ival_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    request_shadow = value;
    settings_used++;
  endtask

  initial begin
    int unsigned     phase;
    int unsigned     first_item;
    int unsigned     lead;
    aipc_pkg::ival_t req;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: pulses before arming are ignored.
    push_item(aipc_pkg::CMD_PULSE, '0);
    push_item(aipc_pkg::CMD_PULSE, '1);
    // Arm at the top of the time range with the reset request of one minute.
    push_item(aipc_pkg::CMD_ARM, '1);
    push_item(aipc_pkg::CMD_PULSE, '1);
    push_item(aipc_pkg::CMD_PULSE, '0);
    push_item(aipc_pkg::CMD_PULSE, 32'd100);
    wait_until_idle();

    // A request below the minimum gives ten seconds; a pulse on the deadline closes nothing.
    write_request(17'd0);
    push_item(aipc_pkg::CMD_ARM, '0);
    push_item(aipc_pkg::CMD_PULSE, 32'd10);
    push_item(aipc_pkg::CMD_PULSE, 32'd11);
    push_item(aipc_pkg::CMD_PULSE, 32'd11);
    push_item(aipc_pkg::CMD_PULSE, 32'd5000);
    wait_until_idle();

    // Rounded down to fifty seconds, aligned within the minute.
    write_request(17'd59);
    push_item(aipc_pkg::CMD_ARM, 32'd59);
    push_item(aipc_pkg::CMD_PULSE, 32'd100);
    push_item(aipc_pkg::CMD_PULSE, 32'd101);
    wait_until_idle();

    // Largest request is clamped to a day; the first deadline wraps past zero.
    write_request(17'h1FFFF);
    push_item(aipc_pkg::CMD_ARM, '1);
    push_item(aipc_pkg::CMD_PULSE, '1);
    push_item(aipc_pkg::CMD_PULSE, 32'd90000);
    wait_until_idle();

    // A new request only takes effect at the next arm; the tally carries across it.
    write_request(17'd37);
    push_item(aipc_pkg::CMD_PULSE, 32'd200000);
    push_item(aipc_pkg::CMD_ARM, 32'd200017);
    push_item(aipc_pkg::CMD_PULSE, 32'd200100);
    push_item(aipc_pkg::CMD_PULSE, 32'h8000_0000);
    wait_until_idle();

    // Random part: one request and one idling pattern per phase, drained in between.
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      if (phase < $size(corner_requests)) req = corner_requests[phase];
      else if ($urandom_range(1) == 1) req = aipc_pkg::ival_t'($urandom);
      else req = aipc_pkg::ival_t'($urandom_range(700));
      write_request(req);
      first_item = items_queued;
      // Some phases keep pulsing on the old interval before the new arm.
      if (phase % 2 == 1) begin
        lead = $urandom_range(3, 1);
        repeat (lead) queue_pulse();
      end
      while (items_queued - first_item < PhaseItems)
        queue_sequence($urandom_range(30, 4));
      wait_until_idle();
    end

    $display("Run covered %0d arm and %0d pulse transactions over %0d request settings.",
             arms_seen, pulses_seen, settings_used);
    $display("%0d reports checked, %0d of them followed by a multi-interval catch-up.",
             reports_seen, catchups);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("%0t: timeout with %0d reports outstanding", $time, expected_reports.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/aipc_pkg.sv
hdl/aligned_interval_pulse_counter.sv
hdl/aipc_checker.sv
tb/sv/tb_aligned_interval_pulse_counter.sv
